FILE: rtl/lzss_pkg.sv
// Package for the LZSS window decoder: window geometry, request and result
// types, sequencer and phase encodings, and the window port bundle.
// No dependencies.
package lzss_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int WINDOW_AW   = $clog2(WINDOW_SIZE);

    localparam logic [WINDOW_AW-1:0] WINDOW_LAST  = WINDOW_AW'(WINDOW_SIZE - 1);
    localparam logic [WINDOW_AW-1:0] WRITE_START  = WINDOW_AW'(1);
    localparam logic [2:0]           TAG_POS_LAST = 3'd7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       chunk_start;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       chunk_done;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } emit_t;

    typedef struct packed {
        logic                 we;
        logic [WINDOW_AW-1:0] waddr;
        logic [7:0]           wdata;
        logic                 re;
        logic [WINDOW_AW-1:0] raddr;
    } win_req_t;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_EMIT  = 4'b1000
    } seq_state_t;

    typedef enum logic [3:0] {
        PH_TAG    = 4'b0001,
        PH_TOKEN  = 4'b0010,
        PH_MATCH2 = 4'b0100,
        PH_DONE   = 4'b1000
    } phase_t;

endpackage

FILE: rtl/lzss_if.sv
// Valid/ready channel interfaces for compressed-byte requests and decoded results.
// Depends on lzss_pkg.
interface lzss_in_if
    import lzss_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lzss_out_if
    import lzss_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/lzss_window.sv
// History window of the decoder: one write port and one read port with
// registered read data. Depends on lzss_pkg.
module lzss_window
    import lzss_pkg::*;
(
    input  logic       clk,
    input  win_req_t   req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [WINDOW_SIZE];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/lzss_ctrl.sv
// Token parser and copy sequencer: decodes tag, literal and match bytes and
// steps the window read and write addresses one byte at a time. Depends on lzss_pkg.
module lzss_ctrl
    import lzss_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  in_item_t   in_data,
    output logic       in_ready,
    input  logic       out_free,
    output emit_t      emit,
    output win_req_t   win_req,
    input  logic [7:0] rd_data
);

    seq_state_t           state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [7:0]           tag_reg, tag_next;
    logic [2:0]           pos_reg, pos_next;
    logic [7:0]           held_reg, held_next;
    logic [WINDOW_AW-1:0] wi_reg, wi_next;
    logic [WINDOW_AW-1:0] off_reg, off_next;
    logic [WINDOW_AW-1:0] clr_reg, clr_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic [7:0]           byte_reg, byte_next;
    logic                 from_mem_reg, from_mem_next;
    logic                 done_reg, done_next;
    logic                 accept;
    logic [WINDOW_AW-1:0] match_off;
    logic [7:0]           emit_byte;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign match_off = {in_data.in_byte, held_reg[7:4]};
    assign emit_byte = from_mem_reg ? rd_data : byte_reg;

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        tag_next      = tag_reg;
        pos_next      = pos_reg;
        held_next     = held_reg;
        wi_next       = wi_reg;
        off_next      = off_reg;
        clr_next      = clr_reg;
        cnt_next      = cnt_reg;
        byte_next     = byte_reg;
        from_mem_next = from_mem_reg;
        done_next     = done_reg;
        emit          = '0;
        win_req       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                win_req.we    = 1'b1;
                win_req.waddr = clr_reg;
                win_req.wdata = 8'h00;
                clr_next      = clr_reg + 1'b1;
                if (clr_reg == WINDOW_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.chunk_start)
                    begin
                        tag_next   = in_data.in_byte;
                        pos_next   = '0;
                        held_next  = '0;
                        wi_next    = WRITE_START;
                        phase_next = PH_TOKEN;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_TAG:
                            begin
                                tag_next   = in_data.in_byte;
                                pos_next   = '0;
                                phase_next = PH_TOKEN;
                            end
                            PH_TOKEN:
                            begin
                                if (!tag_reg[pos_reg])
                                begin
                                    byte_next     = in_data.in_byte;
                                    from_mem_next = 1'b0;
                                    done_next     = 1'b0;
                                    cnt_next      = '0;
                                    state_next    = ST_EMIT;
                                end
                                else
                                begin
                                    held_next  = in_data.in_byte;
                                    phase_next = PH_MATCH2;
                                end
                            end
                            PH_MATCH2:
                            begin
                                if (match_off == '0)
                                begin
                                    byte_next     = 8'h00;
                                    from_mem_next = 1'b0;
                                    done_next     = 1'b1;
                                    cnt_next      = '0;
                                    state_next    = ST_EMIT;
                                end
                                else
                                begin
                                    off_next      = match_off;
                                    cnt_next      = {1'b0, held_reg[3:0]} + 5'd1;
                                    from_mem_next = 1'b1;
                                    done_next     = 1'b0;
                                    state_next    = ST_READ;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            ST_READ:
            begin
                win_req.re    = 1'b1;
                win_req.raddr = off_reg;
                state_next    = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit.valid           = 1'b1;
                    emit.item.out_byte   = emit_byte;
                    emit.item.run_last   = (cnt_reg == '0);
                    emit.item.chunk_done = done_reg;
                    if (done_reg)
                    begin
                        phase_next = PH_DONE;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        win_req.we    = 1'b1;
                        win_req.waddr = wi_reg;
                        win_req.wdata = emit_byte;
                        wi_next       = wi_reg + 1'b1;
                        if (cnt_reg != '0)
                        begin
                            cnt_next   = cnt_reg - 5'd1;
                            off_next   = off_reg + 1'b1;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                            if (pos_reg != TAG_POS_LAST)
                            begin
                                pos_next   = pos_reg + 3'd1;
                                phase_next = PH_TOKEN;
                            end
                            else
                            begin
                                pos_next   = '0;
                                phase_next = PH_TAG;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            phase_reg <= PH_TAG;
            tag_reg   <= '0;
            pos_reg   <= '0;
            held_reg  <= '0;
            wi_reg    <= WRITE_START;
            clr_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            tag_reg   <= tag_next;
            pos_reg   <= pos_next;
            held_reg  <= held_next;
            wi_reg    <= wi_next;
            clr_reg   <= clr_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg      <= off_next;
        byte_reg     <= byte_next;
        from_mem_reg <= from_mem_next;
    end

endmodule

FILE: rtl/lzss_window_decoder.sv
// Sequence: once its request is accepted, a literal or end-of-chunk result passes through the
// EMIT state, which waits until the output register is free, into that register; each of the L
// bytes of a match of length L is read from the window in READ and then passed on by EMIT.
// Flow: tag and first match bytes leave the decoder ready for the next request, while a literal
// or a copy holds off requests until emitted; each copied byte uses the shared window read port.
// Reset: asynchronous; a clearing pass then zeroes every window entry before the first request.
module lzss_window_decoder
    import lzss_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lzss_in_if.sink       in_ch,
    lzss_out_if.source    out_ch
);

    emit_t      emit;
    win_req_t   win_req;
    logic [7:0] rd_data;
    logic       out_free;
    logic       out_valid_reg;
    out_item_t  out_data_reg;

    assign out_free = !out_valid_reg || out_ch.ready;

    lzss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_data  (in_ch.data),
        .in_ready (in_ch.ready),
        .out_free (out_free),
        .emit     (emit),
        .win_req  (win_req),
        .rd_data  (rd_data)
    );

    lzss_window u_window (
        .clk     (clk),
        .req     (win_req),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_data_reg <= emit.item;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

FILE: rtl/lzss_checker.sv
// Port-level checks for the LZSS window decoder, attached by bind.
// Depends on lzss_pkg and lzss_window_decoder.
module lzss_assertions
    import lzss_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result changed while stalled");

    a_done_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.chunk_done |-> out_data.run_last && out_data.out_byte == 8'h00)
        else $error("end-of-chunk result malformed");

    a_clear_busy: assert property (@(posedge clk)
        !$past(rst_n) |-> !in_ready)
        else $error("request taken before window clear");

endmodule

bind lzss_window_decoder lzss_assertions u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

FILE: tb/lzss_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the LZSS window decoder: mirrors the decoder state and window,
// predicts the decoded bytes of every accepted request and compares the results.
// Depends on lzss_pkg and the channel interfaces in lzss_if.
module lzss_checker
    import lzss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    lzss_in_if   in_ch,
    lzss_out_if  out_ch,
    output int   fail_count,
    output int   pending,
    output int   checked
);

    logic [7:0]           window_mem [WINDOW_SIZE];
    phase_t               dec_phase;
    logic [7:0]           tag_bits;
    logic [2:0]           tag_pos;
    logic [7:0]           held_byte;
    logic [WINDOW_AW-1:0] wr_ptr;
    out_item_t            decoded_q [$];

    task automatic push_decoded(input logic [7:0] b, input logic last, input logic done);
        out_item_t item;
        item.out_byte   = b;
        item.run_last   = last;
        item.chunk_done = done;
        decoded_q.push_back(item);
    endtask

    task automatic store_byte(input logic [7:0] b);
        window_mem[wr_ptr] = b;
        wr_ptr = wr_ptr + 1'b1;
    endtask

    task automatic advance_token();
        if (tag_pos != TAG_POS_LAST)
        begin
            tag_pos   = tag_pos + 1'b1;
            dec_phase = PH_TOKEN;
        end
        else
        begin
            tag_pos   = '0;
            dec_phase = PH_TAG;
        end
    endtask

    task automatic decode_request(input in_item_t req);
        logic [WINDOW_AW-1:0] rd_ptr;
        logic [7:0]           v;
        int                   run_len;
        if (req.chunk_start)
        begin
            tag_bits  = req.in_byte;
            tag_pos   = '0;
            held_byte = '0;
            wr_ptr    = WRITE_START;
            dec_phase = PH_TOKEN;
            return;
        end
        case (dec_phase)
            PH_TAG:
            begin
                tag_bits  = req.in_byte;
                tag_pos   = '0;
                dec_phase = PH_TOKEN;
            end
            PH_TOKEN:
            begin
                if (!tag_bits[tag_pos])
                begin
                    store_byte(req.in_byte);
                    push_decoded(req.in_byte, 1'b1, 1'b0);
                    advance_token();
                end
                else
                begin
                    held_byte = req.in_byte;
                    dec_phase = PH_MATCH2;
                end
            end
            PH_MATCH2:
            begin
                rd_ptr  = {req.in_byte, held_byte[7:4]};
                run_len = int'(held_byte[3:0]) + 2;
                if (rd_ptr == '0)
                begin
                    push_decoded(8'h00, 1'b1, 1'b1);
                    dec_phase = PH_DONE;
                end
                else
                begin
                    for (int k = 0; k < run_len; k++)
                    begin
                        v = window_mem[rd_ptr];
                        store_byte(v);
                        push_decoded(v, k == run_len - 1, 1'b0);
                        rd_ptr = rd_ptr + 1'b1;
                    end
                    advance_token();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic check_result(input out_item_t got);
        out_item_t want;
        checked++;
        if (decoded_q.size() == 0)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: result with nothing outstanding: byte %h last %b done %b",
                         $realtime, got.out_byte, got.run_last, got.chunk_done);
            return;
        end
        want = decoded_q.pop_front();
        if (got.out_byte !== want.out_byte || got.run_last !== want.run_last ||
            got.chunk_done !== want.chunk_done)
        begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: mismatch: expected byte %h last %b done %b, got byte %h last %b done %b",
                         $realtime, want.out_byte, want.run_last, want.chunk_done,
                         got.out_byte, got.run_last, got.chunk_done);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_SIZE; i++)
                window_mem[i] = 8'h00;
            dec_phase  = PH_TAG;
            tag_bits   = '0;
            tag_pos    = '0;
            held_byte  = '0;
            wr_ptr     = WRITE_START;
            decoded_q.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                decode_request(in_ch.data);
            if (out_ch.valid && out_ch.ready)
                check_result(out_ch.data);
            pending = decoded_q.size();
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Top of the LZSS window decoder testbench: clock, reset, compressed-byte stimulus,
// result back-pressure and the verdict. Depends on lzss_pkg, lzss_if and lzss_checker.
module testbench
    import lzss_pkg::*;
;

    typedef enum int {
        CHUNK_OPEN,
        CHUNK_CLOSED,
        CHUNK_CUT
    } chunk_end_t;

    localparam int RANDOM_REQUESTS = 380;
    localparam int LONG_HOLD       = 400;

    logic clk = 1'b0;
    logic rst_n;

    lzss_in_if  in_ch ();
    lzss_out_if out_ch ();

    int                   fail_count;
    int                   pending;
    int                   checked;
    int                   requests_sent = 0;
    bit                   calm = 1'b0;
    bit                   hold_off = 1'b0;
    logic [WINDOW_AW-1:0] wpos = WRITE_START;

    lzss_window_decoder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    lzss_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("lzss_window_decoder test failed");
        $finish;
    end

    task automatic send_req(input logic [7:0] b, input logic start);
        in_item_t req;
        req.in_byte     = b;
        req.chunk_start = start;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= req;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic send_literal(input logic [7:0] b);
        send_req(b, 1'b0);
        wpos = wpos + 1'b1;
    endtask

    task automatic send_match(input logic [WINDOW_AW-1:0] off, input int len);
        logic [3:0] len_code;
        len_code = 4'(len - 2);
        send_req({off[3:0], len_code}, 1'b0);
        send_req(off[11:4], 1'b0);
        wpos = wpos + WINDOW_AW'(len);
    endtask

    task automatic send_end();
        send_req({4'h0, 4'($urandom_range(0, 15))}, 1'b0);
        send_req(8'h00, 1'b0);
    endtask

    task automatic send_noise(input int count, input bit allow_start);
        for (int i = 0; i < count; i++)
            send_req(8'($urandom_range(0, 255)), allow_start && $urandom_range(0, 5) == 0);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [WINDOW_AW-1:0] pick_offset();
        logic [WINDOW_AW-1:0] off;
        case ($urandom_range(0, 3))
            0:       off = wpos - WINDOW_AW'($urandom_range(1, 4));
            1:       off = WINDOW_AW'($urandom_range(1, WINDOW_SIZE - 1));
            2:       off = 12'hFF0 | WINDOW_AW'($urandom_range(0, 15));
            default: off = WINDOW_AW'($urandom_range(1, (wpos > 1) ? wpos - 1 : 1));
        endcase
        if (off == '0)
            off = 12'h001;
        return off;
    endfunction

    task automatic play_chunk(input int ntags, input chunk_end_t ending, input bit heavy);
        logic [7:0] tag;
        int         stop_pos;
        bit         stop;
        stop = 1'b0;
        for (int t = 0; t < ntags && !stop; t++)
        begin
            tag      = heavy ? 8'hFF : 8'($urandom_range(0, 255));
            stop_pos = -1;
            if (ending != CHUNK_OPEN && t == ntags - 1)
            begin
                stop_pos      = $urandom_range(0, 7);
                tag[stop_pos] = 1'b1;
            end
            send_req(tag, t == 0);
            if (t == 0)
                wpos = WRITE_START;
            for (int i = 0; i < 8 && !stop; i++)
            begin
                if (i == stop_pos)
                begin
                    stop = 1'b1;
                    if (ending == CHUNK_CLOSED)
                        send_end();
                    else
                        send_req(8'($urandom_range(0, 255)), 1'b0);
                end
                else if (!tag[i])
                    send_literal(8'($urandom_range(0, 255)));
                else
                    send_match(pick_offset(), heavy ? 17 : $urandom_range(2, 17));
            end
        end
    endtask

    initial
    begin : receiver
        int idle_left;
        idle_left = 0;
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_off = 1'b0;
            end
            else if (calm)
                out_ch.ready <= 1'b1;
            else if (idle_left > 0)
            begin
                out_ch.ready <= 1'b0;
                idle_left--;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                out_ch.ready <= 1'b0;
                idle_left = $urandom_range(1, 6) - 1;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int stop_at;
        int round;
        int kind;
        rst_n       <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Decoding starts without a chunk start request.
        send_req(8'h06, 1'b0);
        send_literal(8'h00);
        send_match(12'h001, 17);
        send_match(12'hFFF, 2);
        send_literal(8'hFF);
        send_literal(8'hFF);
        // A chunk cut short with a first match byte still held.
        send_req(8'h02, 1'b1);
        send_literal(8'hA5);
        send_req(8'h3C, 1'b0);
        // Zero offset ends the chunk; later requests are ignored.
        send_req(8'h01, 1'b1);
        send_req(8'h0F, 1'b0);
        send_req(8'h00, 1'b0);
        send_req(8'h55, 1'b0);
        send_req(8'hAA, 1'b0);
        // Eight literals, then a fresh tag without a chunk start.
        send_req(8'h00, 1'b1);
        for (int i = 0; i < 8; i++)
            send_literal(8'(8'h80 + i * 8'h11));
        send_req(8'h01, 1'b0);
        send_end();
        drain_results();

        stop_at = requests_sent + RANDOM_REQUESTS;
        round   = 0;
        while (requests_sent < stop_at)
        begin
            if (requests_sent > stop_at - 70)
                calm = 1'b1;
            round++;
            if (round == 4)
            begin
                hold_off = 1'b1;
                play_chunk(3, CHUNK_CLOSED, 1'b1);
            end
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                play_chunk($urandom_range(1, 4), CHUNK_CLOSED, 1'b0);
                send_noise($urandom_range(0, 2), 1'b0);
            end
            else if (kind == 7)
                play_chunk($urandom_range(1, 3), CHUNK_CUT, 1'b0);
            else if (kind == 8)
                send_noise($urandom_range(1, 4), 1'b1);
            else
                play_chunk($urandom_range(1, 2), CHUNK_OPEN, 1'b0);
            if (round == 6)
                drain_results();
        end
        in_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Sent %0d compressed requests and checked %0d decoded results,", requests_sent,
                 checked);
        $display("covering literals, overlapping and wrapping copies, chunk ends and cut chunks.");
        if (fail_count == 0 && pending == 0)
            $display("lzss_window_decoder test passed");
        else
            $display("lzss_window_decoder test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lzss_pkg.sv
rtl/lzss_if.sv
rtl/lzss_window.sv
rtl/lzss_ctrl.sv
rtl/lzss_window_decoder.sv
rtl/lzss_checker.sv
tb/lzss_checker.sv
tb/testbench.sv
